/* rtl/fweo_pkg.sv */
// ----------------------------------------------------------------------------
// fweo_pkg: shared types and constants for the four-wheel encoder odometry
// Holds the sequencer states, the shared multiply/divide unit controls,
// register indexes, fixed-point constants and the CORDIC angle table.
// ----------------------------------------------------------------------------
package fweo_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MPC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TPM = 2'd1;

    localparam logic [31:0] MPC_RESET = 32'd2570450;
    localparam logic [31:0] TPM_RESET = 32'd2448298000;

    localparam logic signed [33:0] INV_GAIN = 34'sd652032874;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] US_PER_S_SCALE = 32'd15625;
    localparam logic [63:0] RATE_MAG_LIMIT = 64'h0004_0000_0000_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_D,
        S_MUL_E,
        S_MUL_H,
        S_CORDIC,
        S_MUL_X,
        S_MUL_Y,
        S_MUL_SPD,
        S_DIV_SPD,
        S_MUL_TRN,
        S_DIV_TRN,
        S_OUT
    } state_t;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } mdu_op_t;

    typedef struct packed {
        logic    start;
        mdu_op_t op;
    } mdu_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mdu_stat_t;

    function automatic logic [31:0] atan_angle(input logic [4:0] idx);
        logic [31:0] a;
        unique case (idx)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2F9;
            5'd15: a = 32'h0000517C;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A2F;
            5'd19: a = 32'h00000517;
            5'd20: a = 32'h0000028B;
            5'd21: a = 32'h00000145;
            5'd22: a = 32'h000000A2;
            5'd23: a = 32'h00000051;
            5'd24: a = 32'h00000028;
            5'd25: a = 32'h00000014;
            5'd26: a = 32'h0000000A;
            5'd27: a = 32'h00000005;
            5'd28: a = 32'h00000002;
            5'd29: a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

    // Saturated Q16.16 rate from a quotient, its sign and an overrange flag.
    function automatic logic [31:0] rate_sat(input logic neg, input logic big,
                                             input logic [63:0] quo);
        logic [63:0] lim;
        logic [63:0] q;
        lim = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
        q = big ? lim : quo;
        if (q > lim) begin
            q = lim;
        end
        return neg ? (32'd0 - q[31:0]) : q[31:0];
    endfunction

endpackage

/* rtl/fweo_if.sv */
// ----------------------------------------------------------------------------
// fweo_if: sample and result channels
// Valid/ready channels carrying the encoder sample and the odometry result.
// ----------------------------------------------------------------------------
interface fweo_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] count_a;
    logic signed [31:0] count_b;
    logic signed [31:0] count_c;
    logic signed [31:0] count_d;
    logic        [19:0] elapsed_us;

    modport source (output valid, count_a, count_b, count_c, count_d, elapsed_us,
                    input ready);
    modport sink (input valid, count_a, count_b, count_c, count_d, elapsed_us,
                  output ready);
endinterface

interface fweo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [31:0] heading;
    logic signed [31:0] speed;
    logic signed [31:0] turn_rate;
    logic               time_zero;

    modport source (output valid, pos_x, pos_y, heading, speed, turn_rate, time_zero,
                    input ready);
    modport sink (input valid, pos_x, pos_y, heading, speed, turn_rate, time_zero,
                  output ready);
endinterface

/* rtl/fweo_mdu.sv */
// ----------------------------------------------------------------------------
// fweo_mdu: shared iterative multiply/divide unit
// Shift-add multiply of 64 by 32 bits in 32 steps, restoring divide of
// 64 by 32 bits in 64 steps; the result is held after the done pulse.
// ----------------------------------------------------------------------------
module fweo_mdu (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fweo_pkg::mdu_ctrl_t  ctrl,
    input  logic [63:0]          opa,
    input  logic [31:0]          opb,
    output fweo_pkg::mdu_stat_t  stat,
    output logic [95:0]          product
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [5:0]          cnt_reg, cnt_next;
    fweo_pkg::mdu_op_t   op_reg, op_next;
    logic [95:0]         a_reg, a_next;
    logic [31:0]         b_reg, b_next;
    logic [95:0]         acc_reg, acc_next;
    logic [32:0]         rem_reg, rem_next;
    logic [32:0]         rem_shift;
    logic                fits;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        rem_shift = {rem_reg[31:0], a_reg[63]};
        fits      = rem_shift >= {1'b0, b_reg};
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            op_next   = ctrl.op;
            a_next    = {32'd0, opa};
            b_next    = opb;
            acc_next  = '0;
            rem_next  = '0;
            cnt_next  = (ctrl.op == fweo_pkg::OP_MUL) ? 6'd31 : 6'd63;
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                fweo_pkg::OP_MUL:
                begin
                    if (b_reg[0])
                    begin
                        acc_next = acc_reg + a_reg;
                    end
                    a_next = {a_reg[94:0], 1'b0};
                    b_next = {1'b0, b_reg[31:1]};
                end
                fweo_pkg::OP_DIV:
                begin
                    rem_next = fits ? (rem_shift - {1'b0, b_reg}) : rem_shift;
                    a_next   = {32'd0, a_reg[62:0], fits};
                end
                default:
                begin
                    a_next = a_reg;
                end
            endcase
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= fweo_pkg::OP_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = (op_reg == fweo_pkg::OP_MUL) ? acc_reg : {32'd0, a_reg[63:0]};

endmodule

/* rtl/four_wheel_encoder_odometry.sv */
// ----------------------------------------------------------------------------
// four_wheel_encoder_odometry: four-wheel encoder odometry
// Turns absolute wheel counts into pose, speed and turn rate using one
// shared multiply/divide unit and an iterative CORDIC under a sequencer.
// ----------------------------------------------------------------------------
// Each sample runs through seven multiplies and two divides on the shared unit,
// the CORDIC steps and the output step; a new sample is taken only in the idle
// state, once the previous one has left the output step. A stalled receiver
// holding the result register holds the sequencer in the output step.
// Reset clears pose, heading and previous counts and loads register defaults.
// ----------------------------------------------------------------------------
module four_wheel_encoder_odometry #(
    parameter int unsigned CORDIC_STEPS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    fweo_in_if.sink                        sample,
    fweo_out_if.source                     result,
    input  logic                           cfg_we,
    input  logic [fweo_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);

    localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

    fweo_pkg::state_t    state_reg, state_next;
    logic                started_reg, started_next;
    logic [4:0]          step_reg, step_next;
    logic [31:0]         mpc_reg, mpc_next;
    logic [31:0]         tpm_reg, tpm_next;
    logic [31:0]         prev_reg [4];
    logic [31:0]         prev_next [4];
    logic signed [31:0]  pos_x_reg, pos_x_next;
    logic signed [31:0]  pos_y_reg, pos_y_next;
    logic [31:0]         heading_reg, heading_next;
    logic                out_valid_reg, out_valid_next;

    logic [33:0]         smag_reg, smag_next;
    logic                sneg_reg, sneg_next;
    logic [33:0]         dmag_src_reg, dmag_src_next;
    logic                eneg_reg, eneg_next;
    logic [19:0]         us_reg, us_next;
    logic [63:0]         dmag_reg, dmag_next;
    logic [63:0]         emag_reg, emag_next;
    logic [63:0]         hmag_reg, hmag_next;
    logic signed [33:0]  cx_reg, cx_next;
    logic signed [33:0]  cy_reg, cy_next;
    logic signed [33:0]  cz_reg, cz_next;
    logic                flip_reg, flip_next;
    logic [63:0]         prod_reg, prod_next;
    logic [31:0]         speed_reg, speed_next;
    logic [31:0]         turn_reg, turn_next;
    logic [31:0]         o_x_reg, o_x_next;
    logic [31:0]         o_y_reg, o_y_next;
    logic [31:0]         o_hd_reg, o_hd_next;
    logic [31:0]         o_sp_reg, o_sp_next;
    logic [31:0]         o_tr_reg, o_tr_next;
    logic                o_tz_reg, o_tz_next;

    fweo_pkg::mdu_ctrl_t mdu_ctrl;
    fweo_pkg::mdu_stat_t mdu_stat;
    logic [63:0]         mdu_opa;
    logic [31:0]         mdu_opb;
    logic [95:0]         mdu_prod;

    logic signed [31:0]  d_a, d_b, d_c, d_d;
    logic signed [33:0]  sum4, diff2;
    logic [31:0]         fold_sum;
    logic                fold;
    logic [31:0]         fold_angle;
    logic signed [33:0]  xs, ys, atan_s;
    logic signed [33:0]  cos_s, sin_s, fac;
    logic [31:0]         fac_mag;
    logic                fac_neg;
    logic [49:0]         travel;
    logic signed [50:0]  pos_old, pos_sum;
    logic signed [31:0]  pos_sat;
    logic                out_free;

    fweo_mdu u_mdu (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mdu_ctrl),
        .opa     (mdu_opa),
        .opb     (mdu_opb),
        .stat    (mdu_stat),
        .product (mdu_prod)
    );

    assign sample.ready = (state_reg == fweo_pkg::S_IDLE);
    assign out_free     = !out_valid_reg || result.ready;

    always_comb
    begin
        d_a = sample.count_a - prev_reg[0];
        d_b = sample.count_b - prev_reg[1];
        d_c = sample.count_c - prev_reg[2];
        d_d = sample.count_d - prev_reg[3];
        sum4  = 34'(d_a) + 34'(d_b) + 34'(d_c) + 34'(d_d);
        diff2 = (34'(d_a) + 34'(d_d)) - (34'(d_b) + 34'(d_c));

        fold_sum   = heading_reg + fweo_pkg::QUARTER_TURN;
        fold       = fold_sum[31];
        fold_angle = heading_reg ^ {fold, 31'd0};

        xs     = cx_reg >>> step_reg;
        ys     = cy_reg >>> step_reg;
        atan_s = signed'({2'b00, fweo_pkg::atan_angle(step_reg)});

        cos_s   = flip_reg ? -cx_reg : cx_reg;
        sin_s   = flip_reg ? -cy_reg : cy_reg;
        fac     = (state_reg == fweo_pkg::S_MUL_Y) ? sin_s : cos_s;
        fac_neg = fac[33];
        fac_mag = fac_neg ? 32'(-fac) : 32'(fac);

        travel  = mdu_prod[95:46];
        pos_old = (state_reg == fweo_pkg::S_MUL_Y) ? 51'(pos_y_reg) : 51'(pos_x_reg);
        pos_sum = (sneg_reg != fac_neg) ? (pos_old - signed'({1'b0, travel}))
                                        : (pos_old + signed'({1'b0, travel}));
        if (pos_sum > 51'sd2147483647)
        begin
            pos_sat = 32'sh7FFF_FFFF;
        end
        else if (pos_sum < -51'sd2147483648)
        begin
            pos_sat = 32'sh8000_0000;
        end
        else
        begin
            pos_sat = 32'(pos_sum);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        started_next   = started_reg;
        step_next      = step_reg;
        mpc_next       = mpc_reg;
        tpm_next       = tpm_reg;
        prev_next      = prev_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        heading_next   = heading_reg;
        out_valid_next = out_valid_reg;
        smag_next      = smag_reg;
        sneg_next      = sneg_reg;
        dmag_src_next  = dmag_src_reg;
        eneg_next      = eneg_reg;
        us_next        = us_reg;
        dmag_next      = dmag_reg;
        emag_next      = emag_reg;
        hmag_next      = hmag_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        flip_next      = flip_reg;
        prod_next      = prod_reg;
        speed_next     = speed_reg;
        turn_next      = turn_reg;
        o_x_next       = o_x_reg;
        o_y_next       = o_y_reg;
        o_hd_next      = o_hd_reg;
        o_sp_next      = o_sp_reg;
        o_tr_next      = o_tr_reg;
        o_tz_next      = o_tz_reg;
        mdu_ctrl.start = 1'b0;
        mdu_ctrl.op    = fweo_pkg::OP_MUL;
        mdu_opa        = dmag_reg;
        mdu_opb        = mpc_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                fweo_pkg::CFG_MPC: mpc_next = cfg_data;
                fweo_pkg::CFG_TPM: tpm_next = cfg_data;
                default: mpc_next = mpc_reg;
            endcase
        end

        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            fweo_pkg::S_IDLE:
            begin
                if (sample.valid)
                begin
                    prev_next[0]  = sample.count_a;
                    prev_next[1]  = sample.count_b;
                    prev_next[2]  = sample.count_c;
                    prev_next[3]  = sample.count_d;
                    sneg_next     = sum4[33];
                    smag_next     = sum4[33] ? 34'(-sum4) : 34'(sum4);
                    eneg_next     = diff2[33];
                    dmag_src_next = diff2[33] ? 34'(-diff2) : 34'(diff2);
                    us_next       = sample.elapsed_us;
                    started_next  = 1'b0;
                    state_next    = fweo_pkg::S_MUL_D;
                end
            end
            fweo_pkg::S_MUL_D:
            begin
                mdu_opa = {30'd0, smag_reg};
                mdu_opb = mpc_reg;
                if (mdu_stat.done)
                begin
                    dmag_next  = mdu_prod[65:2];
                    state_next = fweo_pkg::S_MUL_E;
                end
            end
            fweo_pkg::S_MUL_E:
            begin
                mdu_opa = {30'd0, dmag_src_reg};
                mdu_opb = mpc_reg;
                if (mdu_stat.done)
                begin
                    emag_next  = mdu_prod[64:1];
                    state_next = fweo_pkg::S_MUL_H;
                end
            end
            fweo_pkg::S_MUL_H:
            begin
                mdu_opa = emag_reg;
                mdu_opb = tpm_reg;
                if (mdu_stat.done)
                begin
                    hmag_next  = mdu_prod[95:32];
                    flip_next  = fold;
                    cx_next    = fweo_pkg::INV_GAIN;
                    cy_next    = '0;
                    cz_next    = 34'(signed'(fold_angle));
                    step_next  = '0;
                    state_next = fweo_pkg::S_CORDIC;
                end
            end
            fweo_pkg::S_CORDIC:
            begin
                if (!cz_reg[33])
                begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    cz_next = cz_reg - atan_s;
                end
                else
                begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    cz_next = cz_reg + atan_s;
                end
                step_next = step_reg + 5'd1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = fweo_pkg::S_MUL_X;
                end
            end
            fweo_pkg::S_MUL_X:
            begin
                mdu_opa = dmag_reg;
                mdu_opb = fac_mag;
                if (mdu_stat.done)
                begin
                    pos_x_next = pos_sat;
                    state_next = fweo_pkg::S_MUL_Y;
                end
            end
            fweo_pkg::S_MUL_Y:
            begin
                mdu_opa = dmag_reg;
                mdu_opb = fac_mag;
                if (mdu_stat.done)
                begin
                    pos_y_next = pos_sat;
                    state_next = fweo_pkg::S_MUL_SPD;
                end
            end
            fweo_pkg::S_MUL_SPD:
            begin
                mdu_opa = dmag_reg;
                mdu_opb = fweo_pkg::US_PER_S_SCALE;
                if (mdu_stat.done)
                begin
                    prod_next  = mdu_prod[63:0];
                    state_next = fweo_pkg::S_DIV_SPD;
                end
            end
            fweo_pkg::S_DIV_SPD:
            begin
                mdu_ctrl.op = fweo_pkg::OP_DIV;
                mdu_opa     = prod_reg;
                mdu_opb     = {2'b00, us_reg, 10'd0};
                if (mdu_stat.done)
                begin
                    speed_next = fweo_pkg::rate_sat(sneg_reg && (dmag_reg != 64'd0),
                                                    dmag_reg >= fweo_pkg::RATE_MAG_LIMIT,
                                                    mdu_prod[63:0]);
                    state_next = fweo_pkg::S_MUL_TRN;
                end
            end
            fweo_pkg::S_MUL_TRN:
            begin
                mdu_opa = hmag_reg;
                mdu_opb = fweo_pkg::US_PER_S_SCALE;
                if (mdu_stat.done)
                begin
                    prod_next  = mdu_prod[63:0];
                    state_next = fweo_pkg::S_DIV_TRN;
                end
            end
            fweo_pkg::S_DIV_TRN:
            begin
                mdu_ctrl.op = fweo_pkg::OP_DIV;
                mdu_opa     = prod_reg;
                mdu_opb     = {2'b00, us_reg, 10'd0};
                if (mdu_stat.done)
                begin
                    turn_next  = fweo_pkg::rate_sat(eneg_reg && (hmag_reg != 64'd0),
                                                    hmag_reg >= fweo_pkg::RATE_MAG_LIMIT,
                                                    mdu_prod[63:0]);
                    state_next = fweo_pkg::S_OUT;
                end
            end
            fweo_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    heading_next   = eneg_reg ? (heading_reg - hmag_reg[31:0])
                                              : (heading_reg + hmag_reg[31:0]);
                    o_x_next       = pos_x_reg;
                    o_y_next       = pos_y_reg;
                    o_hd_next      = heading_next;
                    o_tz_next      = (us_reg == 20'd0);
                    o_sp_next      = (us_reg == 20'd0) ? 32'd0 : speed_reg;
                    o_tr_next      = (us_reg == 20'd0) ? 32'd0 : turn_reg;
                    out_valid_next = 1'b1;
                    state_next     = fweo_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fweo_pkg::S_IDLE;
            end
        endcase

        // The shared unit is started once on entry to each of its states.
        if (state_reg inside {fweo_pkg::S_MUL_D, fweo_pkg::S_MUL_E, fweo_pkg::S_MUL_H,
                              fweo_pkg::S_MUL_X, fweo_pkg::S_MUL_Y, fweo_pkg::S_MUL_SPD,
                              fweo_pkg::S_DIV_SPD, fweo_pkg::S_MUL_TRN,
                              fweo_pkg::S_DIV_TRN})
        begin
            if (!started_reg)
            begin
                mdu_ctrl.start = 1'b1;
                started_next   = 1'b1;
            end
            else if (mdu_stat.done)
            begin
                started_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fweo_pkg::S_IDLE;
            started_reg   <= 1'b0;
            step_reg      <= '0;
            mpc_reg       <= fweo_pkg::MPC_RESET;
            tpm_reg       <= fweo_pkg::TPM_RESET;
            prev_reg      <= '{default: '0};
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            heading_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            step_reg      <= step_next;
            mpc_reg       <= mpc_next;
            tpm_reg       <= tpm_next;
            prev_reg      <= prev_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            heading_reg   <= heading_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smag_reg     <= smag_next;
        sneg_reg     <= sneg_next;
        dmag_src_reg <= dmag_src_next;
        eneg_reg     <= eneg_next;
        us_reg       <= us_next;
        dmag_reg     <= dmag_next;
        emag_reg     <= emag_next;
        hmag_reg     <= hmag_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        cz_reg       <= cz_next;
        flip_reg     <= flip_next;
        prod_reg     <= prod_next;
        speed_reg    <= speed_next;
        turn_reg     <= turn_next;
        o_x_reg      <= o_x_next;
        o_y_reg      <= o_y_next;
        o_hd_reg     <= o_hd_next;
        o_sp_reg     <= o_sp_next;
        o_tr_reg     <= o_tr_next;
        o_tz_reg     <= o_tz_next;
    end

    assign result.valid     = out_valid_reg;
    assign result.pos_x     = o_x_reg;
    assign result.pos_y     = o_y_reg;
    assign result.heading   = o_hd_reg;
    assign result.speed     = o_sp_reg;
    assign result.turn_rate = o_tr_reg;
    assign result.time_zero = o_tz_reg;

    a_mdu_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mdu_ctrl.start |-> !mdu_stat.busy)
        else $error("shared unit started while busy");

    a_transfer_starts_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> (state_reg == fweo_pkg::S_MUL_D))
        else $error("sample transfer did not start the sequence");

    a_time_zero_rates: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.time_zero) |-> (result.speed == 32'sd0 &&
                                                 result.turn_rate == 32'sd0))
        else $error("nonzero rate with zero elapsed time");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg == fweo_pkg::S_OUT))
        else $error("result appeared outside the output step");

endmodule
